>>> rtl/core/bls_pkg.sv
package bls_pkg;

  // Width of the coordinate and color fields on the ports.
  localparam int FIELD_W = 16;

  // Internal coordinate width; coordinates wrap modulo 2**COORD_WIDTH.
  localparam int COORD_WIDTH = 16;
  localparam int TWICE_W     = COORD_WIDTH + 1;
  localparam int ERR_W       = COORD_WIDTH + 3;
  localparam int COUNT_W     = COORD_WIDTH + 1;

  // func codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoded command handed from the front to the back.
  typedef struct packed {
    logic                   is_start;
    logic [COORD_WIDTH-1:0] x0;
    logic [COORD_WIDTH-1:0] y0;
    logic [COORD_WIDTH-1:0] dx;
    logic [COORD_WIDTH-1:0] dy;
    logic                   x_dir_neg;
    logic                   y_dir_neg;
    logic                   x_major;
    logic [FIELD_W-1:0]     color;
  } cmd_t;

endpackage

>>> rtl/core/bls_in_if.sv
interface bls_in_if import bls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [FIELD_W-1:0] x_start;
  logic [FIELD_W-1:0] y_start;
  logic [FIELD_W-1:0] x_end;
  logic [FIELD_W-1:0] y_end;
  logic [FIELD_W-1:0] color;

  modport source (output valid, func, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, color, output ready);
endinterface

>>> rtl/core/bls_out_if.sv
interface bls_out_if import bls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] px;
  logic [FIELD_W-1:0] py;
  logic [FIELD_W-1:0] pixel_color;
  logic               last;

  modport source (output valid, px, py, pixel_color, last, input ready);
  modport sink   (input valid, px, py, pixel_color, last, output ready);
endinterface

>>> rtl/core/bls_front.sv
module bls_front import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bls_in_if.sink   in_ch,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic                   x_neg, y_neg;
  logic [COORD_WIDTH-1:0] x0, y0, x1, y1, dx, dy;
  cmd_t                   cmd_next;

  assign in_ch.ready = !cmd_valid || cmd_ready;

  // Classify the word and work out the absolute spans for a start.
  always_comb begin
    x0    = in_ch.x_start[COORD_WIDTH-1:0];
    y0    = in_ch.y_start[COORD_WIDTH-1:0];
    x1    = in_ch.x_end[COORD_WIDTH-1:0];
    y1    = in_ch.y_end[COORD_WIDTH-1:0];
    x_neg = x1 < x0;
    y_neg = y1 < y0;
    dx    = x_neg ? (x0 - x1) : (x1 - x0);
    dy    = y_neg ? (y0 - y1) : (y1 - y0);
    cmd_next.is_start  = (in_ch.func == FUNC_START);
    cmd_next.x0        = x0;
    cmd_next.y0        = y0;
    cmd_next.dx        = dx;
    cmd_next.dy        = dy;
    cmd_next.x_dir_neg = x_neg;
    cmd_next.y_dir_neg = y_neg;
    cmd_next.x_major   = dx > dy;
    cmd_next.color     = in_ch.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ch.ready) begin
      cmd_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

>>> rtl/core/bls_queue.sv
module bls_queue import bls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign push_ready = count < QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/bls_back.sv
module bls_back import bls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  bls_out_if.source out_ch
);

  logic                     active;
  logic [COORD_WIDTH-1:0]   cur_x, cur_y;
  logic signed [ERR_W-1:0]  err_term;
  logic [TWICE_W-1:0]       twice_dx, twice_dy;
  logic                     x_dir_neg, y_dir_neg, x_major;
  logic [COUNT_W-1:0]       points_left;
  logic [FIELD_W-1:0]       line_color;

  logic                     out_free, take, take_start, take_step, emit;
  logic                     minor_move;
  logic [TWICE_W-1:0]       twice_major, twice_minor;
  logic [COORD_WIDTH-1:0]   d_major, d_minor;
  logic signed [ERR_W-1:0]  err_next, err_load;
  logic [COORD_WIDTH-1:0]   x_next, y_next;

  // Starts never need the output register; steps wait for room in it.
  assign out_free   = !out_ch.valid || out_ch.ready;
  assign cmd_ready  = cmd.is_start || out_free;
  assign take       = cmd_valid && cmd_ready;
  assign take_start = take && cmd.is_start;
  assign take_step  = take && !cmd.is_start;
  assign emit       = take_step && active;

  always_comb begin
    twice_major = x_major ? twice_dx : twice_dy;
    twice_minor = x_major ? twice_dy : twice_dx;
    minor_move  = !err_term[ERR_W-1];
    err_next    = err_term + $signed({2'b00, twice_minor})
                  - (minor_move ? $signed({2'b00, twice_major}) : '0);
    x_next      = cur_x;
    y_next      = cur_y;
    if (x_major || minor_move) begin
      x_next = x_dir_neg ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    if (!x_major || minor_move) begin
      y_next = y_dir_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    d_major  = cmd.x_major ? cmd.dx : cmd.dy;
    d_minor  = cmd.x_major ? cmd.dy : cmd.dx;
    err_load = $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      err_term     <= '0;
      twice_dx     <= '0;
      twice_dy     <= '0;
      x_dir_neg    <= 1'b0;
      y_dir_neg    <= 1'b0;
      x_major      <= 1'b0;
      points_left  <= '0;
      line_color   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (take_start) begin
        active      <= 1'b1;
        cur_x       <= cmd.x0;
        cur_y       <= cmd.y0;
        err_term    <= err_load;
        twice_dx    <= {cmd.dx, 1'b0};
        twice_dy    <= {cmd.dy, 1'b0};
        x_dir_neg   <= cmd.x_dir_neg;
        y_dir_neg   <= cmd.y_dir_neg;
        x_major     <= cmd.x_major;
        points_left <= {1'b0, d_major} + 1'b1;
        line_color  <= cmd.color;
      end else if (emit) begin
        cur_x       <= x_next;
        cur_y       <= y_next;
        err_term    <= err_next;
        points_left <= points_left - 1'b1;
        if (points_left == COUNT_W'(1)) begin
          active <= 1'b0;
        end
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.px          <= FIELD_W'(cur_x);
      out_ch.py          <= FIELD_W'(cur_y);
      out_ch.pixel_color <= line_color;
      out_ch.last        <= (points_left == COUNT_W'(1));
    end
  end

  a_active_has_points: assert property (@(posedge clk) disable iff (rst)
    active |-> points_left != '0)
    else $error("active line with no points left");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && points_left == COUNT_W'(1)) |=> !active)
    else $error("line still active after its final pixel");

  a_emit_shows_word: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_ch.valid)
    else $error("emitted pixel not presented on output");

endmodule

>>> rtl/core/bresenham_line_stepper.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    func, x_start, y_start, x_end, y_end, color
// out_ch    out  valid/ready    px, py, pixel_color, last
//
// One input word per cycle is taken unless a stall holds in_ch; each step word
// on an active line gives one pixel, so a line streams at one pixel per clock
// while out_ch is ready. A step word's pixel passes the front register,
// the command queue and the back stepper with its output register.
// The back stepper takes a step whenever its output register has room.
// rst is synchronous, active high, and leaves the block idle with an empty queue.
// A stall on out_ch backs up through the queue; in_ch keeps taking words until
// the front register and the two-entry queue are full.
module bresenham_line_stepper import bls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bls_in_if.sink    in_ch,
  bls_out_if.source out_ch
);

  // Front -> queue
  logic front_valid, front_ready;
  cmd_t front_cmd;

  // Queue -> back
  logic back_valid, back_ready;
  cmd_t back_cmd;

  // Accept words and decode starts into spans, directions and the major axis.
  bls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Hold decoded commands so the front keeps accepting while the output stalls.
  bls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Run the line: load on start, emit and advance on each step, drop idle steps.
  bls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_ch    (out_ch)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import bls_pkg::*;

  // Give up after this many cycles with no word moving on either channel.
  // The longest legal quiet spell is the receiver's long hold-off.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 80;
  // Tail after the last pixel, long enough to clear the block's depth.
  localparam int TAIL_CYCLES    = 12;
  localparam int WORD_TARGET    = 400;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // One queued input word. A word with drain set is not sent: it tells the
  // driver to hold off until every predicted pixel has come back.
  typedef struct {
    logic               func;
    logic [FIELD_W-1:0] x0, y0, x1, y1, color;
    bit                 drain;
  } word_t;

  typedef struct {
    logic [FIELD_W-1:0] px, py, color;
    logic               last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bls_in_if  in_ch ();
  bls_out_if out_ch ();

  bresenham_line_stepper dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  word_t  word_q[$];
  pixel_t pixel_q[$];

  // Knobs the stimulus thread turns between phases.
  bit       gaps_on  = 1'b1;
  rx_mode_t rx_mode  = RX_OPEN;
  int       hold_tag = 0;

  int n_queued     = 0;
  int n_errors     = 0;
  int n_lines      = 0;
  int n_replaced   = 0;
  int n_live_steps = 0;
  int n_idle_steps = 0;
  int n_pixels     = 0;
  int n_finished   = 0;
  int n_drains     = 0;

  // ---------------------------------------------------------------------------
  // Line tracker: our own copy of the stepper state, advanced on every word
  // the block accepts. Steps on a live line append the pixel they must produce.
  // ---------------------------------------------------------------------------
  logic                          ln_active = 1'b0;
  logic        [COORD_WIDTH-1:0] ln_x = '0, ln_y = '0;
  logic signed [ERR_W-1:0]       ln_err = '0;
  logic        [TWICE_W-1:0]     ln_twice_dx = '0, ln_twice_dy = '0;
  logic                          ln_x_neg = 1'b0, ln_y_neg = 1'b0, ln_x_major = 1'b0;
  logic        [COUNT_W-1:0]     ln_left = '0;
  logic        [FIELD_W-1:0]     ln_color = '0;

  task automatic trace_word(input logic func, input logic [FIELD_W-1:0] x0, y0, x1, y1,
                            input logic [FIELD_W-1:0] color);
    logic [COORD_WIDTH-1:0] cx0, cy0, cx1, cy1, dx, dy;
    int e;
    if (func == FUNC_START) begin
      n_lines++;
      if (ln_active) n_replaced++;
      cx0 = x0[COORD_WIDTH-1:0];
      cy0 = y0[COORD_WIDTH-1:0];
      cx1 = x1[COORD_WIDTH-1:0];
      cy1 = y1[COORD_WIDTH-1:0];
      ln_x_neg    = cx1 < cx0;
      ln_y_neg    = cy1 < cy0;
      dx          = ln_x_neg ? cx0 - cx1 : cx1 - cx0;
      dy          = ln_y_neg ? cy0 - cy1 : cy1 - cy0;
      ln_twice_dx = TWICE_W'(dx) << 1;
      ln_twice_dy = TWICE_W'(dy) << 1;
      // Ties, including the single-point line, go to the y axis.
      ln_x_major  = dx > dy;
      if (ln_x_major) begin
        e       = int'(ln_twice_dy) - int'(dx);
        ln_left = COUNT_W'(dx) + 1'b1;
      end else begin
        e       = int'(ln_twice_dx) - int'(dy);
        ln_left = COUNT_W'(dy) + 1'b1;
      end
      ln_err    = e[ERR_W-1:0];
      ln_x      = cx0;
      ln_y      = cy0;
      ln_color  = color;
      ln_active = 1'b1;
    end else if (!ln_active) begin
      n_idle_steps++;
    end else begin
      n_live_steps++;
      pixel_q.push_back('{px: FIELD_W'(ln_x), py: FIELD_W'(ln_y), color: ln_color,
                          last: ln_left == 1});
      e = int'(ln_err);
      // Emit first, then advance: the minor axis moves on a non-negative error.
      if (ln_x_major) begin
        if (e >= 0) begin
          e    = e - int'(ln_twice_dx);
          ln_y = ln_y_neg ? ln_y - 1'b1 : ln_y + 1'b1;
        end
        e    = e + int'(ln_twice_dy);
        ln_x = ln_x_neg ? ln_x - 1'b1 : ln_x + 1'b1;
      end else begin
        if (e >= 0) begin
          e    = e - int'(ln_twice_dy);
          ln_x = ln_x_neg ? ln_x - 1'b1 : ln_x + 1'b1;
        end
        e    = e + int'(ln_twice_dx);
        ln_y = ln_y_neg ? ln_y - 1'b1 : ln_y + 1'b1;
      end
      ln_err  = e[ERR_W-1:0];
      ln_left = ln_left - 1'b1;
      if (ln_left == 0) ln_active = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want, got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch on pixel %0d, expected %h, got %h",
               $time, name, n_pixels, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: send queued words in bursts with gaps between them. valid is only
  // touched when the slot is free, so a held word stays stable under back-pressure.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;
  bit draining   = 1'b0;

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (draining && pixel_q.size() == 0) draining = 1'b0;
      if (!draining && word_q.size() > 0 && word_q[0].drain) begin
        void'(word_q.pop_front());
        draining = 1'b1;
        n_drains++;
      end
      if (draining || word_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        w = word_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.func    <= w.func;
        in_ch.x_start <= w.x0;
        in_ch.y_start <= w.y0;
        in_ch.x_end   <= w.x1;
        in_ch.y_end   <= w.y1;
        in_ch.color   <= w.color;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = gaps_on ? $urandom_range(1, 8) : 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: open mode keeps ready high; the other modes alternate open and
  // stalled runs. A bump of hold_tag starts one long hold-off, counted down here.
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;
  int rx_run    = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_run = 0;
    end else begin
      if (hold_seen != hold_tag) begin
        hold_seen = hold_tag;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_run = 0;
        out_ch.ready <= 1'b0;
      end else if (rx_run > 0) begin
        rx_run--;
      end else begin
        case (rx_mode)
          RX_OPEN: begin
            out_ch.ready <= 1'b1;
          end
          RX_LIGHT: begin
            out_ch.ready <= !out_ch.ready;
            rx_run = out_ch.ready ? $urandom_range(0, 1) : $urandom_range(1, 11);
          end
          default: begin
            out_ch.ready <= !out_ch.ready;
            rx_run = out_ch.ready ? $urandom_range(0, 7) : $urandom_range(0, 3);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the pixel word first, then fold any accepted input word into
  // the tracker, so one process owns the pixel queue at each edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{px: out_ch.px, py: out_ch.py, color: out_ch.pixel_color, last: out_ch.last};
        if (got.last === 1'b1) n_finished++;
        if (pixel_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected pixel, expected none, got px %h py %h color %h last %b",
                   $time, got.px, got.py, got.color, got.last);
        end else begin
          want = pixel_q.pop_front();
          check_field("px", want.px, got.px);
          check_field("py", want.py, got.py);
          check_field("pixel_color", want.color, got.color);
          check_field("last", FIELD_W'(want.last), FIELD_W'(got.last));
        end
        n_pixels++;
      end
      if (in_ch.valid && in_ch.ready)
        trace_word(in_ch.func, in_ch.x_start, in_ch.y_start, in_ch.x_end, in_ch.y_end,
                   in_ch.color);
    end
  end

  // Watchdog: a long spell with nothing accepted on either side means a hang.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d pixels still owed",
               $time, WATCHDOG_LIMIT, pixel_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic func, input logic [FIELD_W-1:0] x0, y0, x1, y1,
                           input logic [FIELD_W-1:0] color);
    word_q.push_back('{func: func, x0: x0, y0: y0, x1: x1, y1: y1, color: color,
                       drain: 1'b0});
    n_queued++;
  endtask

  // Step words carry random junk in the endpoint fields; the block must ignore it.
  task automatic push_step();
    push_word(FUNC_STEP, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  task automatic push_drain();
    word_q.push_back('{func: FUNC_STEP, x0: '0, y0: '0, x1: '0, y1: '0, color: '0,
                       drain: 1'b1});
  endtask

  // Move c by d in a random direction without leaving the coordinate range.
  function automatic logic [FIELD_W-1:0] shift_coord(input logic [FIELD_W-1:0] c,
                                                     input int d);
    if (int'(c) + d > 65535 || (int'(c) >= d && $urandom_range(0, 1)))
      return c - FIELD_W'(d);
    return c + FIELD_W'(d);
  endfunction

  // Queue one line: a start word and a run of steps. Most runs play the line
  // out exactly; some stop early so the next start drops it, some overrun it.
  task automatic push_line(input int span);
    logic [FIELD_W-1:0] x0, y0, x1, y1;
    int dx, dy, pts, n_step, pick;
    x0 = FIELD_W'($urandom);
    y0 = FIELD_W'($urandom);
    if (span > 1000) begin
      x1 = FIELD_W'($urandom);
      y1 = FIELD_W'($urandom);
    end else begin
      dx = $urandom_range(0, span);
      dy = $urandom_range(0, span);
      case ($urandom_range(0, 3))
        0:       dy = 0;
        1:       dx = 0;
        2:       dy = dx;
        default: ;
      endcase
      x1 = shift_coord(x0, dx);
      y1 = shift_coord(y0, dy);
    end
    dx  = x1 > x0 ? int'(x1 - x0) : int'(x0 - x1);
    dy  = y1 > y0 ? int'(y1 - y0) : int'(y0 - y1);
    pts = (dx > dy ? dx : dy) + 1;
    pick = $urandom_range(0, 19);
    if (pick < 14)      n_step = pts;
    else if (pick < 17) n_step = $urandom_range(0, pts - 1);
    else                n_step = pts + $urandom_range(1, 3);
    if (n_step > 30 && span > 1000) n_step = $urandom_range(1, 30);
    // Now and then slip in a stray word of either kind.
    if ($urandom_range(0, 11) == 0)
      push_word($urandom_range(0, 1) ? FUNC_STEP : FUNC_START, FIELD_W'($urandom),
                FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                FIELD_W'($urandom));
    push_word(FUNC_START, x0, y0, x1, y1, FIELD_W'($urandom));
    repeat (n_step) push_step();
  endtask

  task automatic push_random(input int upto);
    while (n_queued < upto) begin
      if ($urandom_range(0, 24) == 0) push_line(65535);
      else if ($urandom_range(0, 7) == 0) push_line(40);
      else push_line(10);
    end
  endtask

  task automatic wait_words_sent();
    while (word_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_START;
    in_ch.x_start = '0;
    in_ch.y_start = '0;
    in_ch.x_end   = '0;
    in_ch.y_end   = '0;
    in_ch.color   = '0;
    out_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines, light stalls on both sides.
    gaps_on <= 1'b1;
    rx_mode <= RX_LIGHT;
    push_step();                                                       // step with no line
    push_word(FUNC_START, 16'd40, 16'd40, 16'd40, 16'd40, 16'hFFFF);   // single point
    push_step();
    push_step();                                                       // back to idle
    push_word(FUNC_START, 16'h0000, 16'hFFFF, 16'h0003, 16'hFFFE, 16'h0000);
    repeat (4) push_step();                                            // shallow, y falling
    push_word(FUNC_START, 16'hFFFF, 16'h0000, 16'hFFFD, 16'h0003, 16'hA5A5);
    repeat (4) push_step();                                            // steep, x falling
    push_word(FUNC_START, 16'd5, 16'd5, 16'd7, 16'd7, 16'h5A5A);
    repeat (3) push_step();                                            // 45 degrees
    push_word(FUNC_START, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hF800);
    repeat (2) push_step();                                            // full span, cut short
    push_word(FUNC_START, 16'd100, 16'd200, 16'd100, 16'd202, 16'h07E0);
    push_step();                                                       // replaces the one above

    push_random(150);
    wait_words_sent();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender streams a 40-point line with no gaps, so the block fills and
    // stalls its input. Then pause until every pixel is home.
    gaps_on  <= 1'b0;
    rx_mode  <= RX_OPEN;
    hold_tag <= hold_tag + 1;
    push_word(FUNC_START, 16'd1000, 16'd2000, 16'd1039, 16'd1977, 16'h1234);
    repeat (40) push_step();
    push_drain();
    wait_words_sent();

    // A stretch with no idling at all.
    push_random(280);
    wait_words_sent();

    // Heavy stalls on both sides to finish.
    gaps_on <= 1'b1;
    rx_mode <= RX_HEAVY;
    push_random(WORD_TARGET);
    wait_words_sent();

    while (in_ch.valid) @(negedge clk);
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d words: %0d lines (%0d cut off by a new start), %0d live steps, %0d idle",
             n_queued, n_lines, n_replaced, n_live_steps, n_idle_steps);
    $display("Checked %0d pixels, %0d line ends, %0d drain pauses, %0d errors",
             n_pixels, n_finished, n_drains, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
